// ===== rtl/byte_stream_framer_macros.svh =====
// assertion macros for the byte stream framer
// clk and rst_n are taken from the module that uses them
`ifndef BYTE_STREAM_FRAMER_MACROS_SVH
`define BYTE_STREAM_FRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define BSF_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("byte_stream_framer: check failed");

// consequent holds in the same cycle as the antecedent
`define BSF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte_stream_framer: check failed");

// consequent holds in the cycle after the antecedent
`define BSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte_stream_framer: check failed");

`else

`define BSF_ASSERT(label, cond)
`define BSF_ASSERT_IMPL(label, ante, cons)
`define BSF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/bsf_pkg.sv =====
package bsf_pkg;

    localparam int DEF_BUFFER_DEPTH = 64;
    localparam int DEF_MAX_MARK     = 4;

    localparam int BYTE_W     = 8;
    localparam int MARK_W     = 32;
    localparam int CFG_LEN_W  = 7;
    localparam int MARK_LEN_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 5;

    // output queue
    localparam int FIFO_DEPTH = 2;
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } bsf_word_t;

endpackage

// ===== rtl/bsf_mark_match.sv =====
module bsf_mark_match
#(
    parameter int MAX_MARK = bsf_pkg::DEF_MAX_MARK
)
(
    input  logic [bsf_pkg::BYTE_W*MAX_MARK-1:0] window,
    input  logic [bsf_pkg::MARK_W-1:0]          mark_bytes,
    input  logic [$clog2(MAX_MARK+1)-1:0]       mark_len,
    output logic                                hit
);
    import bsf_pkg::*;

    localparam int ML_W    = $clog2(MAX_MARK + 1);
    localparam int MARK_NB = MARK_W / BYTE_W;

    logic [MAX_MARK-1:0] byte_ok;

    // window byte 0 is the newest and lines up with the low mark byte
    for (genvar j = 0; j < MAX_MARK; j++) begin : g_byte
        logic [BYTE_W-1:0] mark_byte;
        if (j < MARK_NB) begin : g_in
            assign mark_byte = mark_bytes[BYTE_W*j +: BYTE_W];
        end
        else begin : g_out
            assign mark_byte = '0;
        end
        assign byte_ok[j] = (ML_W'(j) >= mark_len) ||
                            (window[BYTE_W*j +: BYTE_W] == mark_byte);
    end

    assign hit = &byte_ok;

endmodule

// ===== rtl/bsf_out_fifo.sv =====
module bsf_out_fifo
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  bsf_pkg::bsf_word_t         push_word,
    input  logic                       pop,
    output bsf_pkg::bsf_word_t         head_word,
    output logic                       valid,
    output logic [bsf_pkg::FILL_W-1:0] fill
);
    import bsf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    bsf_word_t          entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [FILL_W-1:0]  fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head_word = entry_reg[rd_ptr_reg];
    assign valid     = (fill_reg != '0);
    assign fill      = fill_reg;

endmodule

// ===== rtl/byte_stream_framer.sv =====
// Byte stream framer. Takes one byte per word on the data channel and sends
// frames out on the frame channel as a run of words, last_of_frame set on the
// final byte. With enable clear every byte leaves at once as a one-byte frame.
// With enable set the byte joins a buffer held in a single-port-read,
// single-port-write memory of BUFFER_DEPTH bytes, kept as a ring. When the
// count passes the smaller of max_buffer and BUFFER_DEPTH the buffer is
// dropped and nothing leaves. In fixed mode every complete frame of
// frame_length bytes leaves (0 counts as 1); in delimiter mode the buffer
// through the first occurrence of the mark leaves, and with mark_length 0 the
// whole buffer leaves. A frame is read out of the buffer memory one byte per
// cycle while the output queue has room, and the next byte is taken once the
// last read of the frame is issued. The mark is normally checked against the
// newest bytes as they arrive; after a register write, a fixed mode step, or
// a frame that left bytes behind, the next byte triggers a rescan of the
// buffer through the same read port, one byte per cycle.
// Output words wait in a two-word queue so the block keeps working while the
// frame channel stalls, until the queue is full. Registers are to be written
// over the APB port only while the block is idle; the user must keep to this,
// the block does not enforce it. There is no clearing pass after reset.
`include "byte_stream_framer_macros.svh"

module byte_stream_framer
#(
    parameter int BUFFER_DEPTH = bsf_pkg::DEF_BUFFER_DEPTH,
    parameter int MAX_MARK     = bsf_pkg::DEF_MAX_MARK
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsf_pkg::PADDR_W-1:0]    paddr,
    input  logic [bsf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bsf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    // incoming bytes
    input  logic                           data_valid,
    output logic                           data_stall,
    input  logic [bsf_pkg::BYTE_W-1:0]     data_byte,
    // outgoing frame bytes
    output logic                           frame_valid,
    input  logic                           frame_stall,
    output logic [bsf_pkg::BYTE_W-1:0]     out_byte,
    output logic                           last_of_frame
);
    import bsf_pkg::*;

    localparam int AW        = $clog2(BUFFER_DEPTH);
    localparam int CW        = $clog2(BUFFER_DEPTH + 2);   // count plus one
    localparam int WIN_W     = BYTE_W * MAX_MARK;
    localparam int ML_W      = $clog2(MAX_MARK + 1);
    localparam int CMP_W     = CFG_LEN_W + 1;
    localparam int REG_IDX_W = PADDR_W - 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ENABLE       = 3'd0,
        REG_FIXED_MODE   = 3'd1,
        REG_FRAME_LENGTH = 3'd2,
        REG_MARK_LENGTH  = 3'd3,
        REG_MARK_BYTES   = 3'd4,
        REG_MAX_BUFFER   = 3'd5
    } reg_sel_t;

    // one-hot control states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic                  enable_reg;
    logic                  fixed_mode_reg;
    logic [CFG_LEN_W-1:0]  frame_length_reg;
    logic [MARK_LEN_W-1:0] mark_length_reg;
    logic [MARK_W-1:0]     mark_bytes_reg;
    logic [CFG_LEN_W-1:0]  max_buffer_reg;

    logic     cfg_wr;
    reg_sel_t reg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_sel_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            fixed_mode_reg   <= 1'b0;
            frame_length_reg <= CFG_LEN_W'(1);
            mark_length_reg  <= '0;
            mark_bytes_reg   <= '0;
            max_buffer_reg   <= CFG_LEN_W'(64);
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_ENABLE:       enable_reg       <= pwdata[0];
                REG_FIXED_MODE:   fixed_mode_reg   <= pwdata[0];
                REG_FRAME_LENGTH: frame_length_reg <= pwdata[CFG_LEN_W-1:0];
                REG_MARK_LENGTH:  mark_length_reg  <= pwdata[MARK_LEN_W-1:0];
                REG_MARK_BYTES:   mark_bytes_reg   <= pwdata[MARK_W-1:0];
                REG_MAX_BUFFER:   max_buffer_reg   <= pwdata[CFG_LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ENABLE:       prdata = APB_DATA_W'(enable_reg);
            REG_FIXED_MODE:   prdata = APB_DATA_W'(fixed_mode_reg);
            REG_FRAME_LENGTH: prdata = APB_DATA_W'(frame_length_reg);
            REG_MARK_LENGTH:  prdata = APB_DATA_W'(mark_length_reg);
            REG_MARK_BYTES:   prdata = APB_DATA_W'(mark_bytes_reg);
            REG_MAX_BUFFER:   prdata = APB_DATA_W'(max_buffer_reg);
            default:          prdata = '0;
        endcase
    end

    // effective settings
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] flen;
    logic [ML_W-1:0]  mark_len_eff;
    logic [3:0]       mark_len_wide;

    assign limit = (CMP_W'(max_buffer_reg) > CMP_W'(BUFFER_DEPTH)) ?
                   CMP_W'(BUFFER_DEPTH) : CMP_W'(max_buffer_reg);
    // zero frame length behaves as one
    assign flen  = (frame_length_reg == '0) ? CMP_W'(1) : CMP_W'(frame_length_reg);
    assign mark_len_wide = 4'(mark_length_reg);
    assign mark_len_eff  = (mark_len_wide > 4'(MAX_MARK)) ?
                           ML_W'(MAX_MARK) : ML_W'(mark_len_wide);

    // ------------------------------------------------------------------
    // buffer memory, kept as a ring starting at head_reg
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] frame_buffer [BUFFER_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            frame_buffer[wr_addr] <= data_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= frame_buffer[rd_addr];
        end
    end

    // ring index: base plus an offset below the depth
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = (AW+1)'(base) + (AW+1)'(off);
        if (sum >= (AW+1)'(BUFFER_DEPTH))
        begin
            sum = sum - (AW+1)'(BUFFER_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    state_t           state_reg,  state_next;
    logic [AW-1:0]    head_reg,   head_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic [CW-1:0]    left_reg,   left_next;    // bytes still to read in this frame
    logic [CW-1:0]    issued_reg, issued_next;  // rescan reads issued
    logic [CW-1:0]    seen_reg,   seen_next;    // rescan bytes returned
    logic             clean_reg,  clean_next;   // no mark occurrence in the buffer
    logic             push_inflight_reg;
    logic             push_last_reg;
    logic             scan_inflight_reg;
    logic [WIN_W-1:0] recent_reg;
    logic [WIN_W-1:0] scan_win_reg;

    logic [WIN_W-1:0] recent_next;
    logic [WIN_W-1:0] scan_win_next;
    logic [CW-1:0]    count_new;
    logic [CW-1:0]    count_dec;
    logic [CW-1:0]    seen_inc;
    logic             tail_hit;
    logic             scan_hit;
    logic             emit_issue;
    logic             scan_issue;
    logic             data_accept;
    logic             pop;
    logic             room;
    logic             out_push;
    bsf_word_t        out_push_word;
    bsf_word_t        out_head;
    logic [FILL_W-1:0] fifo_fill;
    logic [FILL_W:0]  out_load;

    assign count_new     = count_reg + CW'(1);
    assign count_dec     = count_reg - CW'(1);
    assign seen_inc      = seen_reg + CW'(1);
    assign recent_next   = (recent_reg << BYTE_W) | WIN_W'(data_byte);
    assign scan_win_next = (scan_win_reg << BYTE_W) | WIN_W'(rd_data_reg);
    assign wr_addr       = ptr_add(head_reg, count_reg);

    // mark check on the newest bytes, and on the rescan window
    bsf_mark_match #(.MAX_MARK(MAX_MARK)) u_tail_match
    (
        .window     (recent_next),
        .mark_bytes (mark_bytes_reg),
        .mark_len   (mark_len_eff),
        .hit        (tail_hit)
    );

    bsf_mark_match #(.MAX_MARK(MAX_MARK)) u_scan_match
    (
        .window     (scan_win_next),
        .mark_bytes (mark_bytes_reg),
        .mark_len   (mark_len_eff),
        .hit        (scan_hit)
    );

    // output queue credit: queued words plus a read in flight, less a pop
    assign pop      = frame_valid && !frame_stall;
    assign out_load = (FILL_W+1)'(fifo_fill) + (FILL_W+1)'(push_inflight_reg);
    assign room     = out_load < ((FILL_W+1)'(FIFO_DEPTH) + (FILL_W+1)'(pop));

    // pass-through needs the queue free of a pending memory return
    assign data_stall  = !((state_reg == S_IDLE) &&
                           (enable_reg || (!push_inflight_reg && room)));
    assign data_accept = data_valid && !data_stall;

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        left_next   = left_reg;
        issued_next = issued_reg;
        seen_next   = seen_reg;
        clean_next  = clean_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        rd_addr     = head_reg;
        emit_issue  = 1'b0;
        scan_issue  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (data_accept && enable_reg)
                begin
                    mem_we = (count_reg < CW'(BUFFER_DEPTH));
                    if (CMP_W'(count_new) > limit)
                    begin
                        // over the limit: drop the whole buffer
                        count_next = '0;
                        clean_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_new;
                        if (fixed_mode_reg)
                        begin
                            clean_next = 1'b0;
                            if (CMP_W'(count_new) >= flen)
                            begin
                                state_next = S_EMIT;
                                left_next  = CW'(flen);
                            end
                        end
                        else if (mark_len_eff == '0)
                        begin
                            state_next = S_EMIT;
                            left_next  = count_new;
                        end
                        else if (clean_reg)
                        begin
                            // only a match ending at the new byte is possible
                            if ((CMP_W'(count_new) >= CMP_W'(mark_len_eff)) && tail_hit)
                            begin
                                state_next = S_EMIT;
                                left_next  = count_new;
                            end
                        end
                        else
                        begin
                            state_next  = S_SCAN;
                            issued_next = '0;
                            seen_next   = '0;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (issued_reg < count_reg)
                begin
                    mem_re      = 1'b1;
                    rd_addr     = ptr_add(head_reg, issued_reg);
                    issued_next = issued_reg + CW'(1);
                    scan_issue  = 1'b1;
                end
                if (scan_inflight_reg)
                begin
                    seen_next = seen_inc;
                    if ((CMP_W'(seen_inc) >= CMP_W'(mark_len_eff)) && scan_hit)
                    begin
                        state_next = S_EMIT;
                        left_next  = seen_inc;
                    end
                    else if (seen_inc == count_reg)
                    begin
                        state_next = S_IDLE;
                        clean_next = 1'b1;
                    end
                end
            end

            S_EMIT:
            begin
                if (room)
                begin
                    mem_re     = 1'b1;
                    emit_issue = 1'b1;
                    head_next  = ptr_add(head_reg, CW'(1));
                    count_next = count_dec;
                    left_next  = left_reg - CW'(1);
                    if (left_reg == CW'(1))
                    begin
                        // fixed mode sends every complete frame present
                        if (fixed_mode_reg && (CMP_W'(count_dec) >= flen))
                        begin
                            left_next = CW'(flen);
                        end
                        else
                        begin
                            state_next = S_IDLE;
                            clean_next = (count_dec == '0);
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            head_reg          <= '0;
            count_reg         <= '0;
            left_reg          <= '0;
            issued_reg        <= '0;
            seen_reg          <= '0;
            clean_reg         <= 1'b1;
            push_inflight_reg <= 1'b0;
            push_last_reg     <= 1'b0;
            scan_inflight_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            head_reg          <= head_next;
            count_reg         <= count_next;
            left_reg          <= left_next;
            issued_reg        <= issued_next;
            seen_reg          <= seen_next;
            push_inflight_reg <= emit_issue;
            push_last_reg     <= emit_issue && (left_reg == CW'(1));
            scan_inflight_reg <= scan_issue;
            // a new mark or mode may match anywhere in what is buffered
            if (cfg_wr)
            begin
                clean_reg <= (count_reg == '0);
            end
            else
            begin
                clean_reg <= clean_next;
            end
        end
    end

    // byte windows, newest byte in the low position
    always_ff @(posedge clk)
    begin
        if (data_accept && enable_reg)
        begin
            recent_reg <= recent_next;
        end
        if (scan_inflight_reg)
        begin
            scan_win_reg <= scan_win_next;
        end
    end

    // ------------------------------------------------------------------
    // output queue
    // ------------------------------------------------------------------
    assign out_push = (data_accept && !enable_reg) || push_inflight_reg;

    always_comb
    begin
        if (push_inflight_reg)
        begin
            out_push_word.data = rd_data_reg;
            out_push_word.last = push_last_reg;
        end
        else
        begin
            out_push_word.data = data_byte;
            out_push_word.last = 1'b1;
        end
    end

    bsf_out_fifo u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_word (out_push_word),
        .pop       (pop),
        .head_word (out_head),
        .valid     (frame_valid),
        .fill      (fifo_fill)
    );

    assign out_byte      = out_head.data;
    assign last_of_frame = out_head.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `BSF_ASSERT(a_out_credit, out_load <= (FILL_W+1)'(FIFO_DEPTH))
    `BSF_ASSERT(a_count_bound, CMP_W'(count_reg) <= CMP_W'(BUFFER_DEPTH))
    `BSF_ASSERT_IMPL(a_scan_bound, state_reg == S_SCAN, seen_reg < count_reg)
    `BSF_ASSERT_NEXT(a_mark_frame_done, emit_issue && (left_reg == CW'(1)) && !fixed_mode_reg, state_reg == S_IDLE)

endmodule

// ===== tb/sv/byte_stream_framer_tb.sv =====
module byte_stream_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsf_pkg::*;

    localparam int DEPTH         = DEF_BUFFER_DEPTH;
    localparam int MARK_MAX      = DEF_MAX_MARK;
    localparam int RANDOM_BYTES  = 100;
    // worst rescan plus a full 64 byte readout plus the output queue
    localparam int SETTLE_CYCLES = 160;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int DIRECTED_ROWS = 40;

    // register map, one register every four bytes
    typedef enum logic [2:0] {
        REG_ENABLE,
        REG_FIXED_MODE,
        REG_FRAME_LENGTH,
        REG_MARK_LENGTH,
        REG_MARK_BYTES,
        REG_MAX_BUFFER
    } reg_e;

    // what a row of the directed table does
    //   ROW_WRITE  : register write, done while the block is idle
    //   ROW_BYTE   : data word, result worked out by the frame predictor
    //   ROW_ECHO   : data word that must come straight back as a one-byte frame
    //   ROW_SILENT : data word that must produce nothing
    typedef enum logic [1:0] {ROW_WRITE, ROW_BYTE, ROW_ECHO, ROW_SILENT} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        reg_e        sel;
        logic [31:0] value;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic        data_valid = 1'b0;
    logic        data_stall;
    logic [7:0]  data_byte = '0;

    logic        frame_valid;
    logic        frame_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_frame;

    // how the word on the data channel is to be checked, moves with data_byte
    row_kind_e   byte_kind = ROW_BYTE;

    // random idling controls, changed per phase
    bit          gaps_on = 1'b1;
    bit          stall_on = 1'b1;
    int unsigned stall_left = 0;

    // predictor copy of the registers
    logic        cfg_enable = 1'b0;
    logic        cfg_fixed = 1'b0;
    logic [6:0]  cfg_frame_len = 7'd1;
    logic [2:0]  cfg_mark_len = 3'd0;
    logic [31:0] cfg_mark = '0;
    logic [6:0]  cfg_max_buf = 7'd64;

    // predictor copy of the frame buffer
    logic [7:0]  held_bytes [DEPTH];
    int unsigned held_count = 0;

    // frame words still to arrive, oldest first
    bsf_word_t   frames_due [$];
    // frame words caused by the byte being accepted right now
    bsf_word_t   step_frames [$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned bytes_driven = 0;
    int unsigned bytes_in = 0;
    int unsigned words_out = 0;
    int unsigned reg_writes = 0;

    // directed stimulus: extremes first, then each special behavior in turn
    row_t directed_rows [DIRECTED_ROWS] = '{
        // after reset framing is off, bytes come straight back
        '{ROW_ECHO,   REG_ENABLE,       32'h0000_0000},
        '{ROW_ECHO,   REG_ENABLE,       32'h0000_00ff},
        '{ROW_ECHO,   REG_ENABLE,       32'h0000_00a5},
        // framing on, delimiter mode with an empty mark: every byte leaves alone
        '{ROW_WRITE,  REG_ENABLE,       32'h0000_0001},
        '{ROW_ECHO,   REG_ENABLE,       32'h0000_005a},
        // zero limit drops every byte
        '{ROW_WRITE,  REG_MAX_BUFFER,   32'h0000_0000},
        '{ROW_SILENT, REG_ENABLE,       32'h0000_0011},
        '{ROW_SILENT, REG_ENABLE,       32'h0000_00ee},
        // limit above buffer depth, two byte mark
        '{ROW_WRITE,  REG_MAX_BUFFER,   32'h0000_007f},
        '{ROW_WRITE,  REG_MARK_BYTES,   32'h0000_0d0a},
        '{ROW_WRITE,  REG_MARK_LENGTH,  32'h0000_0002},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_0041},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_000d},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_000a},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_000d},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_0042},
        // disabled with bytes held: pass-through, buffer kept
        '{ROW_WRITE,  REG_ENABLE,       32'h0000_0000},
        '{ROW_ECHO,   REG_ENABLE,       32'h0000_007f},
        // back on, mark changed under the held bytes, length above the maximum
        '{ROW_WRITE,  REG_ENABLE,       32'h0000_0001},
        '{ROW_WRITE,  REG_MARK_BYTES,   32'hdead_beef},
        '{ROW_WRITE,  REG_MARK_LENGTH,  32'h0000_0007},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_00de},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_00ad},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_00be},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_00ef},
        // fixed mode, zero length acts as one
        '{ROW_WRITE,  REG_FIXED_MODE,   32'h0000_0001},
        '{ROW_WRITE,  REG_FRAME_LENGTH, 32'h0000_0000},
        '{ROW_ECHO,   REG_ENABLE,       32'h0000_0080},
        // length cut while bytes are held: several frames from one byte
        '{ROW_WRITE,  REG_FRAME_LENGTH, 32'h0000_0003},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_0001},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_0002},
        '{ROW_WRITE,  REG_FRAME_LENGTH, 32'h0000_0001},
        '{ROW_BYTE,   REG_ENABLE,       32'h0000_0003},
        // frame longer than the buffer never completes, buffer dropped past limit
        '{ROW_WRITE,  REG_FRAME_LENGTH, 32'h0000_0064},
        '{ROW_WRITE,  REG_MAX_BUFFER,   32'h0000_0004},
        '{ROW_SILENT, REG_ENABLE,       32'h0000_0010},
        '{ROW_SILENT, REG_ENABLE,       32'h0000_0020},
        '{ROW_SILENT, REG_ENABLE,       32'h0000_0030},
        '{ROW_SILENT, REG_ENABLE,       32'h0000_0040},
        '{ROW_SILENT, REG_ENABLE,       32'h0000_0050}
    };

    byte_stream_framer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .data_valid    (data_valid),
        .data_stall    (data_stall),
        .data_byte     (data_byte),
        .frame_valid   (frame_valid),
        .frame_stall   (frame_stall),
        .out_byte      (out_byte),
        .last_of_frame (last_of_frame)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // frame predictor
    // ------------------------------------------------------------------

    // mark length in force, clipped to the supported maximum
    function automatic int unsigned used_mark_len();
        return (cfg_mark_len > MARK_MAX) ? MARK_MAX : cfg_mark_len;
    endfunction

    // byte i of an m byte mark, first byte in the highest used position
    function automatic logic [7:0] mark_byte(int unsigned i, int unsigned m);
        return 8'(cfg_mark >> (8 * (m - 1 - i)));
    endfunction

    // front n held bytes leave as one frame, the rest move down
    function automatic void release_front(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            step_frames.push_back('{data: held_bytes[i], last: (i + 1 == n)});
        for (int unsigned i = n; i < held_count; i++)
            held_bytes[i - n] = held_bytes[i];
        held_count -= n;
    endfunction

    // one accepted byte in, the frame words it causes appended to step_frames
    function automatic void split_into_frames(logic [7:0] b);
        int unsigned limit;
        int unsigned len;
        int unsigned m;
        bit          hit;
        if (!cfg_enable)
        begin
            step_frames.push_back('{data: b, last: 1'b1});
            return;
        end
        limit = (cfg_max_buf > DEPTH) ? DEPTH : cfg_max_buf;
        if (held_count < DEPTH)
            held_bytes[held_count] = b;
        held_count++;
        // past the limit the whole buffer is thrown away
        if (held_count > limit)
        begin
            held_count = 0;
            return;
        end
        if (cfg_fixed)
        begin
            len = (cfg_frame_len == 0) ? 1 : cfg_frame_len;
            while (held_count >= len)
                release_front(len);
            return;
        end
        m = used_mark_len();
        if (m == 0)
        begin
            release_front(held_count);
            return;
        end
        // first mark occurrence anywhere in the buffer ends the frame
        for (int unsigned i = 0; i + m <= held_count; i++)
        begin
            hit = 1'b1;
            for (int unsigned j = 0; j < m; j++)
                if (held_bytes[i + j] != mark_byte(j, m))
                    hit = 1'b0;
            if (hit)
            begin
                release_front(i + m);
                return;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    task automatic flag(input string msg);
        errors++;
        $display("%0t: %s", $time, msg);
    endtask

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one word on the data channel, held until taken
    task automatic send_byte(input logic [7:0] b, input row_kind_e kind);
        int unsigned gap;
        data_byte  <= b;
        byte_kind  <= kind;
        data_valid <= 1'b1;
        do
            @(posedge clk);
        while (data_stall);
        bytes_driven++;
        gap = gaps_on ? idle_len() : 0;
        // valid stays up when the next word follows at once
        if (gap != 0)
        begin
            data_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        send_byte(8'($urandom_range(255)), ROW_BYTE);
    endtask

    // first n bytes of the mark in force
    task automatic send_mark(input int unsigned n, input int unsigned m);
        for (int unsigned i = 0; i < n; i++)
            send_byte(mark_byte(i, m), ROW_BYTE);
    endtask

    // stop sending, let every expected word arrive, then give the block time
    // to finish a rescan that produces nothing
    task automatic drain();
        data_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write, predictor update, then read back
    task automatic reg_write(input reg_e sel, input logic [31:0] value);
        logic [31:0] keep;
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // register takes the value at this edge
        case (sel)
            REG_ENABLE:
            begin
                cfg_enable = value[0];
                keep = 32'h0000_0001;
            end
            REG_FIXED_MODE:
            begin
                cfg_fixed = value[0];
                keep = 32'h0000_0001;
            end
            REG_FRAME_LENGTH:
            begin
                cfg_frame_len = value[6:0];
                keep = 32'h0000_007f;
            end
            REG_MARK_LENGTH:
            begin
                cfg_mark_len = value[2:0];
                keep = 32'h0000_0007;
            end
            REG_MARK_BYTES:
            begin
                cfg_mark = value;
                keep = 32'hffff_ffff;
            end
            REG_MAX_BUFFER:
            begin
                cfg_max_buf = value[6:0];
                keep = 32'h0000_007f;
            end
            default:
            begin
                keep = '0;
            end
        endcase
        reg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== (value & keep))
            flag($sformatf("%s read back: expected %08h, actual %08h",
                sel.name(), value & keep, rd));
        // idle before returning so psel never drops and rises in the same step
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // frame channel stall
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        int unsigned gap;
        if (stall_left != 0)
        begin
            stall_left  <= stall_left - 1;
            frame_stall <= 1'b1;
        end
        else
        begin
            gap = stall_on ? idle_len() : 0;
            frame_stall <= (gap != 0);
            stall_left  <= (gap != 0) ? gap - 1 : 0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: prediction on accepted data words, check on frame words
    // both handshakes seen in one process so their order never matters
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        bsf_word_t want;
        if (rst_n)
        begin
            cycles++;
            if (data_valid && !data_stall)
            begin
                bytes_in++;
                step_frames.delete();
                split_into_frames(data_byte);
                case (byte_kind)
                    ROW_ECHO:   frames_due.push_back('{data: data_byte, last: 1'b1});
                    ROW_SILENT: ;
                    default:
                    begin
                        foreach (step_frames[k])
                            frames_due.push_back(step_frames[k]);
                    end
                endcase
            end
            if (frame_valid && !frame_stall)
            begin
                words_out++;
                if (frames_due.size() == 0)
                begin
                    flag($sformatf("frame word: expected none, actual byte %02h last %b",
                        out_byte, last_of_frame));
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (out_byte !== want.data)
                        flag($sformatf("out_byte: expected %02h, actual %02h",
                            want.data, out_byte));
                    if (last_of_frame !== want.last)
                        flag($sformatf("last_of_frame: expected %b, actual %b",
                            want.last, last_of_frame));
                end
            end
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("byte_stream_framer_tb failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial
    begin
        int unsigned pick;
        int unsigned mode;
        int unsigned fl;
        int unsigned mb;
        int unsigned ml;
        int unsigned m;
        int unsigned phase_end;
        int unsigned rand_end;
        bit          moved;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, registers only touched once the block is quiet
        moved = 1'b0;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                if (moved)
                    drain();
                moved = 1'b0;
                reg_write(directed_rows[r].sel, directed_rows[r].value);
            end
            else
            begin
                send_byte(directed_rows[r].value[7:0], directed_rows[r].kind);
                moved = 1'b1;
            end
        end

        // random phases; the buffer carries over from one setting to the next
        rand_end = bytes_driven + RANDOM_BYTES;
        while (bytes_driven < rand_end)
        begin
            drain();
            pick = $urandom_range(9);
            fl = (pick == 0) ? 0 : (pick == 1) ? 64 : (pick == 2) ? 127 :
                 $urandom_range(1, 8);
            pick = $urandom_range(9);
            mb = (pick == 0) ? $urandom_range(0, 3) : (pick == 1) ? 127 :
                 (pick == 2) ? 64 : $urandom_range(16, 63);
            ml = ($urandom_range(5) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            // 0 pass-through, 1..4 delimiter with a mark, 5 empty mark, 6..9 fixed
            mode = $urandom_range(9);
            reg_write(REG_ENABLE, 32'(mode != 0));
            reg_write(REG_FIXED_MODE, 32'(mode >= 6));
            reg_write(REG_FRAME_LENGTH, fl);
            reg_write(REG_MARK_LENGTH, (mode == 5) ? 0 : ml);
            reg_write(REG_MARK_BYTES, $urandom);
            reg_write(REG_MAX_BUFFER, mb);
            gaps_on = ($urandom_range(3) != 0);
            stall_on <= ($urandom_range(3) != 0);
            m = used_mark_len();
            phase_end = bytes_driven + $urandom_range(8, 20);
            while (bytes_driven < phase_end)
            begin
                if (mode >= 1 && mode <= 4)
                begin
                    pick = $urandom_range(7);
                    if (pick < 6)
                    begin
                        // well-formed: random payload closed by the mark
                        repeat ($urandom_range(0, 5)) send_random();
                        send_mark(m, m);
                    end
                    else if (pick == 6)
                    begin
                        // broken: mark cut short
                        send_mark($urandom_range(1, m), m);
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 4)) send_random();
                    end
                end
                else
                begin
                    send_random();
                end
            end
        end

        drain();
        $display("run covered %0d data words in, %0d frame words out, %0d register writes",
            bytes_in, words_out, reg_writes);
        $display("pass-through, fixed and delimiter framing, drops and mid-stream changes");
        if (errors == 0)
            $display("byte_stream_framer_tb passed");
        else
            $display("byte_stream_framer_tb failed");
        $finish;
    end

endmodule

// ===== byte_stream_framer.f =====
+incdir+rtl
rtl/bsf_pkg.sv
rtl/bsf_mark_match.sv
rtl/bsf_out_fifo.sv
rtl/byte_stream_framer.sv
tb/sv/byte_stream_framer_tb.sv
